/* rtl/nbr_age_pkg.sv */
// ----------------------------------------------------------------------------
// nbr_age_pkg
// Shared types and codes of the neighbour table aging engine.
// ----------------------------------------------------------------------------
package nbr_age_pkg;

   // Table geometry default
   localparam int ROUTERS_DEFAULT = 8;

   // Configuration register indexes and widths
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_THIS_ROUTER   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFRESH_VALUE = 1'd1;
   localparam logic [2:0] THIS_ROUTER_RESET   = 3'd1;
   localparam logic [7:0] REFRESH_VALUE_RESET = 8'd20;

   // Request modes
   localparam logic [1:0] MODE_MERGE   = 2'd0;
   localparam logic [1:0] MODE_TICK    = 2'd1;
   localparam logic [1:0] MODE_CONNECT = 2'd2;

   // Response kinds
   localparam logic KIND_TABLE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Connect status codes
   localparam logic [1:0] ST_ADDED   = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic [2:0] other_router;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] table_byte;
      logic [1:0] connect_status;
      logic       last;
   } rsp_type;

endpackage

/* rtl/nbr_age_ram.sv */
// ----------------------------------------------------------------------------
// nbr_age_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nbr_age_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/neighbour_table_aging_engine_top.sv */
// ----------------------------------------------------------------------------
// neighbour_table_aging_engine_top
// Router neighbour table: merge of received tables, aging ticks with removal
// of timed-out routers, and neighbour connects.
// ----------------------------------------------------------------------------
// The ROUTERS x ROUTERS byte table sits in one RAM with a registered read;
// every operation is a read-modify-write sequence over that single port pair,
// one request at a time. A received table byte (mode 0) is merged into the
// table and gives no response. A connect (mode 2) answers with one status
// response: without a table access when the router numbers alone decide it,
// otherwise after scanning the stored list (its count capped at ROUTERS-1);
// a match or a full list ends it with no write, otherwise the neighbour is
// appended and both counters are refreshed. A tick (mode 1) reloads its own
// counter, walks the counters of routers 1 and up, and for a timed-out router
// clears its row and removes it from every other list that holds it; it then
// streams the whole table, one byte per read. A stalled output holds the
// sequence until the output register frees up. Per-entry valid bits make the
// table read as zero after reset, so no clearing pass is needed.
// Configuration writes are taken at any time but are only meant while the
// engine is idle.
// ----------------------------------------------------------------------------
module neighbour_table_aging_engine_top #(
   parameter int ROUTERS = nbr_age_pkg::ROUTERS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  nbr_age_pkg::req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output nbr_age_pkg::rsp_type                  rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [nbr_age_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nbr_age_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import nbr_age_pkg::*;

   localparam int CELLS = ROUTERS * ROUTERS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(ROUTERS);
   localparam logic [CW-1:0] LAST_IDX  = CW'(ROUTERS - 1);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

   typedef enum logic [22:0] {
      S_IDLE      = 23'h000001,
      S_MERGE     = 23'h000002,
      S_CN_CNT    = 23'h000004,
      S_CN_SCAN   = 23'h000008,
      S_CN_WR_NB  = 23'h000010,
      S_CN_WR_CNT = 23'h000020,
      S_CN_WR_SLF = 23'h000040,
      S_CN_WR_OTH = 23'h000080,
      S_RESP      = 23'h000100,
      S_TK_RELOAD = 23'h000200,
      S_TK_CTR_RD = 23'h000400,
      S_TK_CTR    = 23'h000800,
      S_TK_ROWCNT = 23'h001000,
      S_TK_CLR    = 23'h002000,
      S_TK_RM_RD  = 23'h004000,
      S_TK_RM_CNT = 23'h008000,
      S_TK_RM_SCN = 23'h010000,
      S_TK_SH_WR  = 23'h020000,
      S_TK_SH_ZER = 23'h040000,
      S_TK_SH_CNT = 23'h080000,
      S_TK_NEXT_I = 23'h100000,
      S_EM_RD     = 23'h200000,
      S_EM_OUT    = 23'h400000
   } state_type;

   // Table address of a row and column
   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                               input logic [CW-1:0] col);
      cell_addr = AW'(int'(row) * ROUTERS + int'(col));
   endfunction

   // Searchable part of a list: count capped at ROUTERS-1
   function automatic logic [CW-1:0] span(input logic [7:0] count);
      if (int'(count) > ROUTERS - 1) begin
         span = LAST_IDX;
      end else begin
         span = count[CW-1:0];
      end
   endfunction

   state_type state_ff, state_in;

   logic [2:0]       this_router_ff, this_router_in;
   logic [7:0]       refresh_ff, refresh_in;
   logic [CW-1:0]    mrow_ff, mrow_in;
   logic [CW-1:0]    mcol_ff, mcol_in;
   logic             replace_ff, replace_in;
   logic [7:0]       data_ff, data_in;
   logic [CW-1:0]    oth_ff, oth_in;
   logic [1:0]       status_ff, status_in;
   logic [7:0]       cnt_ff, cnt_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [AW-1:0]    e_ff, e_in;
   logic [CELLS-1:0] valid_ff, valid_in;
   logic             rd_valid_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [AW-1:0] raddr;
   logic          wen;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;
   logic [7:0]    ram_q;
   logic [7:0]    rd_byte;
   logic          accept;
   logic          out_free;
   logic          this_ok;
   logic          other_ok;
   logic [CW-1:0] this_row;
   logic [CW-1:0] req_other;

   nbr_age_ram #(
      .WIDTH (8),
      .DEPTH (CELLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wen),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (ram_q)
   );

   // Entries never written read as zero
   assign rd_byte  = rd_valid_ff ? ram_q : 8'd0;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign this_row  = this_router_ff[CW-1:0];
   assign req_other = req_data.other_router[CW-1:0];
   assign this_ok   = (this_router_ff != 3'd0) && (int'(this_router_ff) < ROUTERS);
   assign other_ok  = (req_data.other_router != 3'd0) &&
                      (int'(req_data.other_router) < ROUTERS);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration registers
   always_comb begin
      this_router_in = this_router_ff;
      refresh_in     = refresh_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_THIS_ROUTER:   this_router_in = csr_wdata[2:0];
            CSR_REFRESH_VALUE: refresh_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: table accesses and response generation
   always_comb begin
      state_in     = state_ff;
      mrow_in      = mrow_ff;
      mcol_in      = mcol_ff;
      replace_in   = replace_ff;
      data_in      = data_ff;
      oth_in       = oth_ff;
      status_in    = status_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      raddr        = cell_addr(mrow_ff, mcol_ff);
      wen          = 1'b0;
      waddr        = cell_addr(mrow_ff, mcol_ff);
      wdata        = data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_data.mode == MODE_CONNECT) begin
               raddr = cell_addr(this_row, '0);
            end
            if (accept) begin
               data_in = req_data.data_byte;
               case (req_data.mode)
                  MODE_MERGE: state_in = S_MERGE;
                  MODE_TICK:  state_in = S_TK_RELOAD;
                  MODE_CONNECT: begin
                     oth_in = req_other;
                     if (!this_ok || !other_ok) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else if (req_data.other_router == this_router_ff) begin
                        status_in = ST_PRESENT;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_CN_CNT;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Merge one received byte and advance the position
         S_MERGE: begin
            if (mrow_ff == '0) begin
               wen = (data_ff > rd_byte);
            end else if (mcol_ff == '0) begin
               replace_in = (data_ff > rd_byte);
               wen        = (data_ff > rd_byte);
            end else begin
               wen = replace_ff;
            end
            if (mcol_ff == LAST_IDX) begin
               mcol_in = '0;
               mrow_in = (mrow_ff == LAST_IDX) ? '0 : mrow_ff + CW'(1);
            end else begin
               mcol_in = mcol_ff + CW'(1);
            end
            state_in = S_IDLE;
         end

         // Connect: fetch count, scan list, then append and refresh
         S_CN_CNT: begin
            raddr  = cell_addr(this_row, CW'(1));
            cnt_in = rd_byte;
            n_in   = span(rd_byte);
            k_in   = CW'(1);
            if (span(rd_byte) != '0) begin
               state_in = S_CN_SCAN;
            end else if (int'(rd_byte) >= ROUTERS - 1) begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end else begin
               state_in = S_CN_WR_NB;
            end
         end

         S_CN_SCAN: begin
            raddr = cell_addr(this_row, k_ff + CW'(1));
            if (rd_byte == 8'(oth_ff)) begin
               status_in = ST_PRESENT;
               state_in  = S_RESP;
            end else if (k_ff == n_ff) begin
               if (int'(cnt_ff) >= ROUTERS - 1) begin
                  status_in = ST_FULL;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_CN_WR_NB;
               end
            end else begin
               k_in = k_ff + CW'(1);
            end
         end

         S_CN_WR_NB: begin
            wen      = 1'b1;
            waddr    = cell_addr(this_row, cnt_ff[CW-1:0] + CW'(1));
            wdata    = 8'(oth_ff);
            state_in = S_CN_WR_CNT;
         end

         S_CN_WR_CNT: begin
            wen      = 1'b1;
            waddr    = cell_addr(this_row, '0);
            wdata    = cnt_ff + 8'd1;
            state_in = S_CN_WR_SLF;
         end

         S_CN_WR_SLF: begin
            wen      = 1'b1;
            waddr    = cell_addr('0, this_row);
            wdata    = refresh_ff;
            state_in = S_CN_WR_OTH;
         end

         S_CN_WR_OTH: begin
            wen       = 1'b1;
            waddr     = cell_addr('0, oth_ff);
            wdata     = refresh_ff;
            status_in = ST_ADDED;
            state_in  = S_RESP;
         end

         // Hold the status until the output register frees up
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.result_kind    = KIND_STATUS;
               rsp_data_in.table_byte     = 8'd0;
               rsp_data_in.connect_status = status_ff;
               rsp_data_in.last           = 1'b1;
               state_in                   = S_IDLE;
            end
         end

         // Tick: reload own counter, then walk routers 1 and up
         S_TK_RELOAD: begin
            wen      = this_ok;
            waddr    = cell_addr('0, this_row);
            wdata    = refresh_ff;
            i_in     = CW'(1);
            state_in = S_TK_CTR_RD;
         end

         S_TK_CTR_RD: begin
            raddr    = cell_addr('0, i_ff);
            state_in = S_TK_CTR;
         end

         S_TK_CTR: begin
            raddr = cell_addr(i_ff, '0);
            if (rd_byte != 8'd0) begin
               wen      = 1'b1;
               waddr    = cell_addr('0, i_ff);
               wdata    = rd_byte - 8'd1;
               state_in = S_TK_NEXT_I;
            end else begin
               state_in = S_TK_ROWCNT;
            end
         end

         S_TK_ROWCNT: begin
            k_in     = '0;
            state_in = (rd_byte != 8'd0) ? S_TK_CLR : S_TK_NEXT_I;
         end

         // Clear the timed-out row
         S_TK_CLR: begin
            wen   = 1'b1;
            waddr = cell_addr(i_ff, k_ff);
            wdata = 8'd0;
            if (k_ff == LAST_IDX) begin
               j_in     = CW'(1);
               state_in = S_TK_RM_RD;
            end else begin
               k_in = k_ff + CW'(1);
            end
         end

         // Remove the timed-out router from every other list
         S_TK_RM_RD: begin
            raddr    = cell_addr(j_ff, '0);
            state_in = S_TK_RM_CNT;
         end

         S_TK_RM_CNT: begin
            raddr  = cell_addr(j_ff, CW'(1));
            cnt_in = rd_byte;
            n_in   = span(rd_byte);
            k_in   = CW'(1);
            if ((j_ff == i_ff) || (rd_byte == 8'd0)) begin
               if (j_ff == LAST_IDX) begin
                  state_in = S_TK_NEXT_I;
               end else begin
                  j_in     = j_ff + CW'(1);
                  state_in = S_TK_RM_RD;
               end
            end else begin
               state_in = S_TK_RM_SCN;
            end
         end

         S_TK_RM_SCN: begin
            raddr = cell_addr(j_ff, k_ff + CW'(1));
            if (rd_byte == 8'(i_ff)) begin
               state_in = (k_ff == n_ff) ? S_TK_SH_ZER : S_TK_SH_WR;
            end else if (k_ff == n_ff) begin
               if (j_ff == LAST_IDX) begin
                  state_in = S_TK_NEXT_I;
               end else begin
                  j_in     = j_ff + CW'(1);
                  state_in = S_TK_RM_RD;
               end
            end else begin
               k_in = k_ff + CW'(1);
            end
         end

         // Shift later neighbours left by one
         S_TK_SH_WR: begin
            raddr = cell_addr(j_ff, k_ff + CW'(2));
            wen   = 1'b1;
            waddr = cell_addr(j_ff, k_ff);
            wdata = rd_byte;
            k_in  = k_ff + CW'(1);
            if (k_ff + CW'(1) == n_ff) begin
               state_in = S_TK_SH_ZER;
            end
         end

         S_TK_SH_ZER: begin
            wen      = 1'b1;
            waddr    = cell_addr(j_ff, n_ff);
            wdata    = 8'd0;
            state_in = S_TK_SH_CNT;
         end

         S_TK_SH_CNT: begin
            wen   = 1'b1;
            waddr = cell_addr(j_ff, '0);
            wdata = cnt_ff - 8'd1;
            if (j_ff == LAST_IDX) begin
               state_in = S_TK_NEXT_I;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = S_TK_RM_RD;
            end
         end

         S_TK_NEXT_I: begin
            e_in = '0;
            if (i_ff == LAST_IDX) begin
               state_in = S_EM_RD;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_TK_CTR_RD;
            end
         end

         // Stream the table out, one byte per read
         S_EM_RD: begin
            raddr    = e_ff;
            state_in = S_EM_OUT;
         end

         S_EM_OUT: begin
            raddr = e_ff;
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.result_kind    = KIND_TABLE;
               rsp_data_in.table_byte     = rd_byte;
               rsp_data_in.connect_status = ST_ADDED;
               rsp_data_in.last           = (e_ff == LAST_CELL);
               if (e_ff == LAST_CELL) begin
                  state_in = S_IDLE;
               end else begin
                  e_in     = e_ff + AW'(1);
                  state_in = S_EM_RD;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Mark written entries
   always_comb begin
      valid_in = valid_ff;
      if (wen) begin
         valid_in[waddr] = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         this_router_ff <= THIS_ROUTER_RESET;
         refresh_ff     <= REFRESH_VALUE_RESET;
         mrow_ff        <= '0;
         mcol_ff        <= '0;
         replace_ff     <= 1'b0;
         valid_ff       <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         this_router_ff <= this_router_in;
         refresh_ff     <= refresh_in;
         mrow_ff        <= mrow_in;
         mcol_ff        <= mcol_in;
         replace_ff     <= replace_in;
         valid_ff       <= valid_in;
         rd_valid_ff    <= valid_ff[raddr];
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working registers and payload
   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      oth_ff      <= oth_in;
      status_ff   <= status_in;
      cnt_ff      <= cnt_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      e_ff        <= e_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
